@@ rtl/eegfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package eegfd_pkg;

    // Data bytes carried by a frame with channel data.
    localparam int RAW_BYTES = 24;
    localparam int NUM_CHANS = 8;
    localparam int CHAN_W    = 24;
    localparam int COUNT_W   = 32;

    // Position counter holds 0 up to RAW_BYTES.
    localparam int IDX_W = $clog2(RAW_BYTES + 1);
    // Discard increment holds up to RAW_BYTES + 1.
    localparam int ADD_W = $clog2(RAW_BYTES + 2);

    // Framing markers.
    localparam logic [7:0] MARK_START  = 8'h01;
    localparam logic [7:0] MARK_HEADER = 8'h02;
    localparam logic [7:0] MARK_END    = 8'h03;

    // Frame hunting phases.
    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_HEAD = 2'd1,
        PH_TAIL = 2'd2
    } phase_t;

    // One decoded frame, as presented on the result side.
    typedef struct packed {
        logic                                raw_present;
        logic                                spectrum_flag;
        logic [7:0]                          aux_header;
        logic [NUM_CHANS-1:0][CHAN_W-1:0]    chans;
        logic [COUNT_W-1:0]                  discarded_bytes;
    } frame_t;

    // Control from the parser to the output stage.
    typedef struct packed {
        logic tail_end;
        logic emit;
    } parse_ctl_t;

endpackage

`default_nettype wire

@@ rtl/eegfd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module eegfd_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 byte_valid,
    input  wire logic [7:0]           byte_data,
    output eegfd_pkg::parse_ctl_t     ctl,
    output eegfd_pkg::frame_t         frame
);

    eegfd_pkg::phase_t phase_reg, phase_next;
    logic [eegfd_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [7:0]                    hdr1_reg, hdr1_next;
    logic [7:0]                    hdr2_reg, hdr2_next;
    logic [eegfd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                    pay_reg [eegfd_pkg::RAW_BYTES];

    logic                          last_byte;
    logic                          shift_in;
    logic                          emit;
    logic [eegfd_pkg::ADD_W-1:0]   add_amt;
    logic [eegfd_pkg::COUNT_W:0]   count_sum;

    // The tail ends at the end marker, after the data bytes if any.
    assign last_byte = hdr1_reg[7] ? (idx_reg == eegfd_pkg::IDX_W'(eegfd_pkg::RAW_BYTES))
                                   : 1'b1;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (byte_valid) begin
            case (phase_reg)
                eegfd_pkg::PH_HEAD: begin
                    if (idx_reg == eegfd_pkg::IDX_W'(2)) begin
                        phase_next = (byte_data == eegfd_pkg::MARK_HEADER) ?
                                     eegfd_pkg::PH_TAIL : eegfd_pkg::PH_SEEK;
                    end
                end
                eegfd_pkg::PH_TAIL: begin
                    if (last_byte) begin
                        phase_next = eegfd_pkg::PH_SEEK;
                    end
                end
                default: begin
                    phase_next = (byte_data == eegfd_pkg::MARK_START) ?
                                 eegfd_pkg::PH_HEAD : eegfd_pkg::PH_SEEK;
                end
            endcase
        end
    end

    // Position, header capture, data shift, discard increment and result strobe.
    always_comb begin
        idx_next  = idx_reg;
        hdr1_next = hdr1_reg;
        hdr2_next = hdr2_reg;
        shift_in  = 1'b0;
        emit      = 1'b0;
        add_amt   = '0;
        if (byte_valid) begin
            case (phase_reg)
                eegfd_pkg::PH_HEAD: begin
                    if (idx_reg == eegfd_pkg::IDX_W'(0)) begin
                        hdr1_next = byte_data;
                        idx_next  = eegfd_pkg::IDX_W'(1);
                    end else if (idx_reg == eegfd_pkg::IDX_W'(1)) begin
                        hdr2_next = byte_data;
                        idx_next  = eegfd_pkg::IDX_W'(2);
                    end else begin
                        idx_next = '0;
                        if (byte_data != eegfd_pkg::MARK_HEADER) begin
                            add_amt = eegfd_pkg::ADD_W'(3);
                        end
                    end
                end
                eegfd_pkg::PH_TAIL: begin
                    if (!last_byte) begin
                        shift_in = 1'b1;
                        idx_next = idx_reg + eegfd_pkg::IDX_W'(1);
                    end else begin
                        idx_next = '0;
                        if (byte_data != eegfd_pkg::MARK_END) begin
                            add_amt = hdr1_reg[7] ?
                                      eegfd_pkg::ADD_W'(eegfd_pkg::RAW_BYTES + 1) :
                                      eegfd_pkg::ADD_W'(1);
                        end else begin
                            emit = 1'b1;
                        end
                    end
                end
                default: begin
                    idx_next = '0;
                    if (byte_data != eegfd_pkg::MARK_START) begin
                        add_amt = eegfd_pkg::ADD_W'(1);
                    end
                end
            endcase
        end
    end

    // Saturating discard counter.
    assign count_sum  = {1'b0, count_reg} + (eegfd_pkg::COUNT_W + 1)'(add_amt);
    assign count_next = count_sum[eegfd_pkg::COUNT_W] ? '1
                                                      : count_sum[eegfd_pkg::COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= eegfd_pkg::PH_SEEK;
            idx_reg   <= '0;
            hdr1_reg  <= '0;
            hdr2_reg  <= '0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            hdr1_reg  <= hdr1_next;
            hdr2_reg  <= hdr2_next;
            count_reg <= count_next;
        end
    end

    // Data bytes shift in at the top, so the first byte of a full tail sits at entry 0.
    always_ff @(posedge aclk) begin
        if (shift_in) begin
            for (int i = 0; i < eegfd_pkg::RAW_BYTES - 1; i++) begin
                pay_reg[i] <= pay_reg[i+1];
            end
            pay_reg[eegfd_pkg::RAW_BYTES-1] <= byte_data;
        end
    end

    assign ctl.tail_end = (phase_reg == eegfd_pkg::PH_TAIL) && last_byte;
    assign ctl.emit     = emit;

    assign frame.raw_present     = hdr1_reg[7];
    assign frame.spectrum_flag   = hdr1_reg[6];
    assign frame.aux_header      = hdr2_reg;
    assign frame.discarded_bytes = count_reg;

    // Channel j is data bytes 3j..3j+2, most significant first; zero without data.
    for (genvar j = 0; j < eegfd_pkg::NUM_CHANS; j++) begin : g_chan
        if (3 * j + 2 < eegfd_pkg::RAW_BYTES) begin : g_used
            assign frame.chans[j] = hdr1_reg[7] ?
                                    {pay_reg[3*j], pay_reg[3*j+1], pay_reg[3*j+2]} : '0;
        end else begin : g_unused
            assign frame.chans[j] = '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/eeg_frame_deframer.sv @@
// Latency: a result is valid in the cycle after its end marker byte is transferred.
// Throughput: one byte per cycle; the byte index and header registers take each byte
// in a single pass, and only the byte in the end marker position waits, while the result
// register is full and not being read in that cycle.
// Reset: synchronous, active-low aresetn; the parser returns to hunting for a start
// marker, the discard count clears and the result register empties.
`timescale 1ns / 1ps
`default_nettype none

module eeg_frame_deframer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire logic [7:0]         s_rx_byte,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      logic               m_raw_present,
    output      logic               m_spectrum_flag,
    output      logic [7:0]         m_aux_header,
    output      logic signed [23:0] m_chan0,
    output      logic signed [23:0] m_chan1,
    output      logic signed [23:0] m_chan2,
    output      logic signed [23:0] m_chan3,
    output      logic signed [23:0] m_chan4,
    output      logic signed [23:0] m_chan5,
    output      logic signed [23:0] m_chan6,
    output      logic signed [23:0] m_chan7,
    output      logic [31:0]        m_discarded_bytes
);

    eegfd_pkg::parse_ctl_t ctl;
    eegfd_pkg::frame_t     frame;
    eegfd_pkg::frame_t     out_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  in_xfer;

    // Only the byte that can finish a frame needs a free result slot.
    assign s_ready = !ctl.tail_end || !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    eegfd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (in_xfer),
        .byte_data  (s_rx_byte),
        .ctl        (ctl),
        .frame      (frame)
    );

    // Result register.
    assign m_valid_next = ctl.emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            out_reg <= frame;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_raw_present     = out_reg.raw_present;
    assign m_spectrum_flag   = out_reg.spectrum_flag;
    assign m_aux_header      = out_reg.aux_header;
    assign m_chan0           = out_reg.chans[0];
    assign m_chan1           = out_reg.chans[1];
    assign m_chan2           = out_reg.chans[2];
    assign m_chan3           = out_reg.chans[3];
    assign m_chan4           = out_reg.chans[4];
    assign m_chan5           = out_reg.chans[5];
    assign m_chan6           = out_reg.chans[6];
    assign m_chan7           = out_reg.chans[7];
    assign m_discarded_bytes = out_reg.discarded_bytes;

`ifndef SYNTHESIS
    // A frame is only finished when the result slot can take it.
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |-> (!m_valid_reg || m_ready))
        else $error("frame finished while result register still full");

    // The discard count never goes down.
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (frame.discarded_bytes >= $past(frame.discarded_bytes)))
        else $error("discard count decreased");

    // A frame without data carries zero channels.
    a_no_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.raw_present) |-> (out_reg.chans == '0))
        else $error("channels not zero for frame without data");

    // A result is presented only after an end marker transfer or while waiting.
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(ctl.emit))
        else $error("result appeared without a finished frame");
`endif

endmodule

`default_nettype wire
